// ----- rtl/vcc_pkg.sv -----
// Shared types and constants for the vertical capsule collision pipeline.
package vcc_pkg;

   localparam int POS_W   = 24;
   localparam int LEN_W   = 20;
   localparam int RSUM_W  = LEN_W + 1;
   localparam int SQ_W    = 2 * RSUM_W;
   localparam int ROOT_W  = RSUM_W;
   localparam int QUO_W   = 20;
   localparam int REM_W   = SQ_W + 1;
   localparam int DIVR_W  = ROOT_W + 2;

   typedef struct packed {
      logic signed [POS_W-1:0] self_x;
      logic signed [POS_W-1:0] self_y;
      logic signed [POS_W-1:0] self_z;
      logic [LEN_W-1:0]        self_height;
      logic [LEN_W-1:0]        self_radius;
      logic signed [POS_W-1:0] other_x;
      logic signed [POS_W-1:0] other_y;
      logic signed [POS_W-1:0] other_z;
      logic [LEN_W-1:0]        other_height;
      logic [LEN_W-1:0]        other_radius;
   } req_type;

   typedef struct packed {
      logic                    colliding;
      logic signed [POS_W-1:0] push_x;
      logic signed [POS_W-1:0] push_y;
      logic signed [POS_W-1:0] push_z;
   } rsp_type;

   typedef struct packed {
      logic [2:0]        neg;
      logic [RSUM_W-1:0] ax;
      logic [RSUM_W-1:0] ay;
      logic [RSUM_W-1:0] az;
      logic [RSUM_W-1:0] rsum;
      logic              hit;
   } carry_type;

endpackage

// ----- rtl/vcc_stream_if.sv -----
// Valid/ready stream channel carrying one payload item.
interface vcc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/vertical_capsule_collision.sv -----
// Vertical capsule pair collision test with push vector, fully pipelined.
// Throughput: one item per cycle; the whole pipe holds while rsp is stalled.
// Depth is set by the 21-step square root and the 20-step divider stages.
// Synchronous active-high reset clears all valid bits; payload is not reset.
module vertical_capsule_collision (
   input  logic                 clock,
   input  logic                 reset,
   vcc_stream_if.sink           req_bus,
   vcc_stream_if.source         rsp_bus
);

   localparam int RT_N = vcc_pkg::ROOT_W;
   localparam int DV_N = vcc_pkg::QUO_W;

   logic adv;

   // stage 1: differences
   logic                          s1_val_ff, s1_val_in;
   logic [24:0]                   s1_ax_ff, s1_ax_in, s1_az_ff, s1_az_in;
   logic [25:0]                   s1_ay_ff, s1_ay_in;
   logic [2:0]                    s1_neg_ff, s1_neg_in;
   logic [vcc_pkg::RSUM_W-1:0]    s1_rsum_ff, s1_rsum_in;

   // stage 2: squares
   logic                          s2_val_ff;
   logic [49:0]                   s2_sqx_ff, s2_sqz_ff;
   logic [51:0]                   s2_sqy_ff;
   logic [vcc_pkg::SQ_W-1:0]      s2_rsq_ff;
   vcc_pkg::carry_type            s2_car_ff;

   // root stages
   logic                          rt_val_ff [0:RT_N];
   logic [vcc_pkg::SQ_W-1:0]      rt_rem_ff [0:RT_N];
   logic [vcc_pkg::SQ_W-1:0]      rt_res_ff [0:RT_N];
   vcc_pkg::carry_type            rt_car_ff [0:RT_N];
   vcc_pkg::carry_type            rt_car_in;
   logic [vcc_pkg::SQ_W-1:0]      rt_rem_in [0:RT_N];
   logic [vcc_pkg::SQ_W-1:0]      rt_res_in [0:RT_N];
   logic [51:0]                   sq_sum;
   logic                          s3_hit;

   // divider stages
   logic                          dv_val_ff  [0:DV_N];
   logic [vcc_pkg::REM_W-1:0]     dv_rem_ff  [0:DV_N][0:2];
   logic [vcc_pkg::REM_W-1:0]     dv_rem_in  [0:DV_N][0:2];
   logic [DV_N-1:0]               dv_quo_ff  [0:DV_N][0:2];
   logic [DV_N-1:0]               dv_quo_in  [0:DV_N][0:2];
   logic [vcc_pkg::DIVR_W-1:0]    dv_divr_ff [0:DV_N];
   logic [2:0]                    dv_neg_ff  [0:DV_N];
   logic                          dv_zero_ff [0:DV_N];
   logic                          dv_hit_ff  [0:DV_N];
   logic [vcc_pkg::ROOT_W-1:0]    root_dist;
   logic [vcc_pkg::RSUM_W-1:0]    overlap;
   logic [vcc_pkg::RSUM_W-1:0]    mag_src [0:2];

   // output
   logic                          out_val_ff;
   vcc_pkg::rsp_type              out_ff, out_in;

   assign adv           = !out_val_ff || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign rsp_bus.valid = out_val_ff;
   assign rsp_bus.payload = out_ff;

   always_comb begin
      logic signed [24:0] dx, dz;
      logic signed [26:0] dy, top_s, top_o, sy, oy;
      vcc_pkg::req_type   r;
      r     = req_bus.payload;
      dx    = {r.self_x[23], r.self_x} - {r.other_x[23], r.other_x};
      dz    = {r.self_z[23], r.self_z} - {r.other_z[23], r.other_z};
      sy    = {{3{r.self_y[23]}}, r.self_y};
      oy    = {{3{r.other_y[23]}}, r.other_y};
      top_s = sy + {7'b0, r.self_height};
      top_o = oy + {7'b0, r.other_height};
      if (oy > top_s) begin
         dy = top_s - oy;
      end else if (sy > top_o) begin
         dy = sy - top_o;
      end else begin
         dy = '0;
      end
      s1_val_in  = req_bus.valid;
      s1_ax_in   = dx[24] ? 25'(-dx) : 25'(dx);
      s1_az_in   = dz[24] ? 25'(-dz) : 25'(dz);
      s1_ay_in   = dy[26] ? 26'(-dy) : 26'(dy);
      s1_neg_in  = {dz[24], dy[26], dx[24]};
      s1_rsum_in = {1'b0, r.self_radius} + {1'b0, r.other_radius};
   end

   assign sq_sum = {2'b0, s2_sqx_ff} + s2_sqy_ff + {2'b0, s2_sqz_ff};
   assign s3_hit = sq_sum < {10'b0, s2_rsq_ff};

   always_comb begin
      rt_car_in     = s2_car_ff;
      rt_car_in.hit = s3_hit;
   end

   always_comb begin
      logic [vcc_pkg::SQ_W-1:0] b, t;
      rt_rem_in[0] = s3_hit ? sq_sum[vcc_pkg::SQ_W-1:0] : '0;
      rt_res_in[0] = '0;
      for (int i = 0; i < RT_N; i++) begin
         b = vcc_pkg::SQ_W'(1) << (vcc_pkg::SQ_W - 2 - 2 * i);
         t = rt_res_ff[i] + b;
         if (rt_rem_ff[i] >= t) begin
            rt_rem_in[i+1] = rt_rem_ff[i] - t;
            rt_res_in[i+1] = (rt_res_ff[i] >> 1) + b;
         end else begin
            rt_rem_in[i+1] = rt_rem_ff[i];
            rt_res_in[i+1] = rt_res_ff[i] >> 1;
         end
      end
   end

   assign root_dist  = rt_res_ff[RT_N][vcc_pkg::ROOT_W-1:0];
   assign overlap    = rt_car_ff[RT_N].rsum - root_dist;
   assign mag_src[0] = rt_car_ff[RT_N].ax;
   assign mag_src[1] = rt_car_ff[RT_N].ay;
   assign mag_src[2] = rt_car_ff[RT_N].az;

   always_comb begin
      logic [vcc_pkg::REM_W-1:0] dsh;
      logic [vcc_pkg::SQ_W-1:0]  prod;
      for (int c = 0; c < 3; c++) begin
         prod = mag_src[c] * overlap;
         dv_rem_in[0][c] = {1'b0, prod};
         dv_quo_in[0][c] = '0;
      end
      for (int k = 0; k < DV_N; k++) begin
         dsh = vcc_pkg::REM_W'(dv_divr_ff[k]) << (DV_N - 1 - k);
         for (int c = 0; c < 3; c++) begin
            dv_quo_in[k+1][c] = dv_quo_ff[k][c];
            if (dv_rem_ff[k][c] >= dsh) begin
               dv_rem_in[k+1][c] = dv_rem_ff[k][c] - dsh;
               dv_quo_in[k+1][c][DV_N-1-k] = 1'b1;
            end else begin
               dv_rem_in[k+1][c] = dv_rem_ff[k][c];
            end
         end
      end
   end

   always_comb begin
      logic [vcc_pkg::POS_W-1:0] q [0:2];
      logic [vcc_pkg::POS_W-1:0] p [0:2];
      for (int c = 0; c < 3; c++) begin
         q[c] = vcc_pkg::POS_W'(dv_quo_ff[DV_N][c]);
         if (dv_zero_ff[DV_N]) begin
            p[c] = '0;
         end else if (dv_neg_ff[DV_N][c]) begin
            p[c] = -q[c];
         end else begin
            p[c] = q[c];
         end
      end
      out_in.colliding = dv_hit_ff[DV_N];
      out_in.push_x    = p[0];
      out_in.push_y    = p[1];
      out_in.push_z    = p[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_val_ff  <= 1'b0;
         s2_val_ff  <= 1'b0;
         out_val_ff <= 1'b0;
         for (int i = 0; i <= RT_N; i++) begin
            rt_val_ff[i] <= 1'b0;
         end
         for (int k = 0; k <= DV_N; k++) begin
            dv_val_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         s1_val_ff  <= s1_val_in;
         s2_val_ff  <= s1_val_ff;
         rt_val_ff[0] <= s2_val_ff;
         for (int i = 0; i < RT_N; i++) begin
            rt_val_ff[i+1] <= rt_val_ff[i];
         end
         dv_val_ff[0] <= rt_val_ff[RT_N];
         for (int k = 0; k < DV_N; k++) begin
            dv_val_ff[k+1] <= dv_val_ff[k];
         end
         out_val_ff <= dv_val_ff[DV_N];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ax_ff   <= s1_ax_in;
         s1_ay_ff   <= s1_ay_in;
         s1_az_ff   <= s1_az_in;
         s1_neg_ff  <= s1_neg_in;
         s1_rsum_ff <= s1_rsum_in;

         s2_sqx_ff     <= s1_ax_ff * s1_ax_ff;
         s2_sqy_ff     <= s1_ay_ff * s1_ay_ff;
         s2_sqz_ff     <= s1_az_ff * s1_az_ff;
         s2_rsq_ff     <= s1_rsum_ff * s1_rsum_ff;
         s2_car_ff.neg  <= s1_neg_ff;
         s2_car_ff.ax   <= s1_ax_ff[vcc_pkg::RSUM_W-1:0];
         s2_car_ff.ay   <= s1_ay_ff[vcc_pkg::RSUM_W-1:0];
         s2_car_ff.az   <= s1_az_ff[vcc_pkg::RSUM_W-1:0];
         s2_car_ff.rsum <= s1_rsum_ff;
         s2_car_ff.hit  <= 1'b0;

         rt_rem_ff[0] <= rt_rem_in[0];
         rt_res_ff[0] <= rt_res_in[0];
         rt_car_ff[0] <= rt_car_in;
         for (int i = 0; i < RT_N; i++) begin
            rt_rem_ff[i+1] <= rt_rem_in[i+1];
            rt_res_ff[i+1] <= rt_res_in[i+1];
            rt_car_ff[i+1] <= rt_car_ff[i];
         end

         for (int c = 0; c < 3; c++) begin
            dv_rem_ff[0][c] <= dv_rem_in[0][c];
            dv_quo_ff[0][c] <= dv_quo_in[0][c];
         end
         dv_divr_ff[0] <= {root_dist, 2'b00};
         dv_neg_ff[0]  <= rt_car_ff[RT_N].neg;
         dv_hit_ff[0]  <= rt_car_ff[RT_N].hit;
         dv_zero_ff[0] <= !rt_car_ff[RT_N].hit || (root_dist == '0);
         for (int k = 0; k < DV_N; k++) begin
            for (int c = 0; c < 3; c++) begin
               dv_rem_ff[k+1][c] <= dv_rem_in[k+1][c];
               dv_quo_ff[k+1][c] <= dv_quo_in[k+1][c];
            end
            dv_divr_ff[k+1] <= dv_divr_ff[k];
            dv_neg_ff[k+1]  <= dv_neg_ff[k];
            dv_hit_ff[k+1]  <= dv_hit_ff[k];
            dv_zero_ff[k+1] <= dv_zero_ff[k];
         end

         out_ff <= out_in;
      end
   end

   a_no_push_when_clear: assert property (@(posedge clock) disable iff (reset)
      (out_val_ff && !out_ff.colliding) |->
         (out_ff.push_x == '0 && out_ff.push_y == '0 && out_ff.push_z == '0))
      else $error("push vector nonzero without collision");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !out_val_ff)
      else $error("result valid right after reset");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (!adv) |=> ($stable(dv_val_ff[DV_N]) && $stable(rt_val_ff[RT_N])))
      else $error("pipeline moved during stall");

   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      (dv_val_ff[0] && dv_hit_ff[0]) |->
         (dv_divr_ff[0][vcc_pkg::DIVR_W-1:2] != '1))
      else $error("root out of range for a collision");

endmodule

// ----- tb/vcc_tb_if.sv -----
`timescale 1ns / 1ps
// Shared testbench constants for the vertical capsule collision checks.
package vcc_tb_types;
   localparam int LATENCY  = 46;
   localparam int WDOG_MAX = 20000;
endpackage

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the vertical capsule collision pipeline.
module testbench;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic failed = 1'b0;
   logic quiet = 1'b0;
   int   idle_cycles = 0;
   int   hold_cycles = 0;
   int   sent = 0;
   int   got = 0;
   int   hits = 0;

   vcc_stream_if #(.payload_type(vcc_pkg::req_type)) req_bus ();
   vcc_stream_if #(.payload_type(vcc_pkg::rsp_type)) rsp_bus ();

   vcc_pkg::rsp_type expected_q[$];

   vertical_capsule_collision u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
   end

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint push_part(longint d, longint unsigned ovl,
                                        longint unsigned root_len);
      longint unsigned mag;
      mag = longint'(d < 0 ? -d : d) * ovl / (root_len * 4);
      return d < 0 ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic vcc_pkg::rsp_type predict_push(vcc_pkg::req_type r);
      vcc_pkg::rsp_type p;
      longint           sy, oy, sh, oh, dx, dy, dz;
      longint unsigned  rsum, sq, root_len;
      sy = longint'(r.self_y);
      oy = longint'(r.other_y);
      sh = longint'(r.self_height);
      oh = longint'(r.other_height);
      rsum = longint'(r.self_radius) + longint'(r.other_radius);
      dx = longint'(r.self_x) - longint'(r.other_x);
      dz = longint'(r.self_z) - longint'(r.other_z);
      if (oy > sy + sh) dy = sy + sh - oy;
      else if (sy > oy + oh) dy = sy - (oy + oh);
      else dy = 0;
      sq = dx * dx + dy * dy + dz * dz;
      p = '0;
      p.colliding = (sq < rsum * rsum);
      if (p.colliding) begin
         root_len = root64(sq);
         if (root_len != 0) begin
            p.push_x = vcc_pkg::POS_W'(push_part(dx, rsum - root_len, root_len));
            p.push_y = vcc_pkg::POS_W'(push_part(dy, rsum - root_len, root_len));
            p.push_z = vcc_pkg::POS_W'(push_part(dz, rsum - root_len, root_len));
         end
      end
      return p;
   endfunction

   task automatic send_pair(vcc_pkg::req_type r);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.payload <= r;
      req_bus.valid   <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      expected_q.push_back(predict_push(r));
      sent++;
      @(negedge clock);
   endtask

   function automatic vcc_pkg::req_type random_pair(bit near);
      vcc_pkg::req_type r;
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if (near) begin
         r.other_x = vcc_pkg::POS_W'(r.self_x + $signed($urandom_range(0, 16'hffff)) - 32768);
         r.other_y = vcc_pkg::POS_W'(r.self_y + $signed($urandom_range(0, 20'hfffff)) - 524288);
         r.other_z = vcc_pkg::POS_W'(r.self_z + $signed($urandom_range(0, 16'hffff)) - 32768);
         r.self_x  = (r.self_x >>> 2);
         r.other_x = vcc_pkg::POS_W'(r.self_x + $signed($urandom_range(0, 16'hffff)) - 32768);
         r.self_radius  = vcc_pkg::LEN_W'($urandom_range(0, 20'h0ffff));
         r.other_radius = vcc_pkg::LEN_W'($urandom_range(0, 20'h0ffff));
      end
      return r;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (quiet) begin
         rsp_bus.ready <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles   <= hold_cycles - 1;
         rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         hold_cycles   <= $urandom_range(0, 11);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      vcc_pkg::rsp_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got++;
         if (expected_q.size() == 0) begin
            $error("unexpected item: %p", rsp_bus.payload);
            failed = 1'b1;
         end else begin
            e = expected_q.pop_front();
            if (e.colliding) hits++;
            if (rsp_bus.payload.colliding !== e.colliding) begin
               $error("colliding exp %0d got %0d", e.colliding, rsp_bus.payload.colliding);
               failed = 1'b1;
            end
            if (rsp_bus.payload.push_x !== e.push_x) begin
               $error("push_x exp %0d got %0d", e.push_x, rsp_bus.payload.push_x);
               failed = 1'b1;
            end
            if (rsp_bus.payload.push_y !== e.push_y) begin
               $error("push_y exp %0d got %0d", e.push_y, rsp_bus.payload.push_y);
               failed = 1'b1;
            end
            if (rsp_bus.payload.push_z !== e.push_z) begin
               $error("push_z exp %0d got %0d", e.push_z, rsp_bus.payload.push_z);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= vcc_tb_types::WDOG_MAX) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic vcc_pkg::req_type make_pair(int sx, int sy, int sz, int sh, int sr,
                                                  int ox, int oy, int oz, int oh, int orad);
      vcc_pkg::req_type r;
      r.self_x = vcc_pkg::POS_W'(sx);
      r.self_y = vcc_pkg::POS_W'(sy);
      r.self_z = vcc_pkg::POS_W'(sz);
      r.self_height = vcc_pkg::LEN_W'(sh);
      r.self_radius = vcc_pkg::LEN_W'(sr);
      r.other_x = vcc_pkg::POS_W'(ox);
      r.other_y = vcc_pkg::POS_W'(oy);
      r.other_z = vcc_pkg::POS_W'(oz);
      r.other_height = vcc_pkg::LEN_W'(oh);
      r.other_radius = vcc_pkg::LEN_W'(orad);
      return r;
   endfunction

   task automatic test_directed();
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(make_pair(0, 0, 0, 4096, 4096, 0, 0, 0, 4096, 4096));
      send_pair(make_pair(100, 0, 50, 4096, 8192, 0, 10000, 0, 4096, 8192));
      send_pair(make_pair(100, 20000, 50, 4096, 8192, 0, 0, 0, 4096, 8192));
      send_pair(make_pair(300, 0, -200, 8192, 4096, 0, 1000, 0, 8192, 4096));
      send_pair(make_pair(8388607, 8388607, 8388607, 20'hfffff, 20'hfffff,
                          -8388608, -8388608, -8388608, 20'hfffff, 20'hfffff));
      send_pair(make_pair(-8388608, -8388608, -8388608, 20'hfffff, 20'hfffff,
                          8388607, 8388607, 8388607, 20'hfffff, 20'hfffff));
      send_pair(make_pair(-8388608, 8388607, 0, 0, 20'hfffff,
                          -8388608, -8388608, 0, 0, 20'hfffff));
      send_pair(make_pair(0, 0, 0, 20'hfffff, 20'hfffff, 5, 3, -7, 20'hfffff, 20'hfffff));
      send_pair(make_pair(8192, 0, 0, 0, 4096, 0, 0, 0, 0, 4096));
      send_pair(make_pair(-1, -1, -1, 1, 1, 0, 0, 0, 1, 1));
      send_pair(make_pair(0, 0, 0, 0, 20'hfffff, 0, 0, 0, 0, 0));
   endtask

   task automatic test_random(int count);
      repeat (count) send_pair(random_pair($urandom_range(0, 3) != 0));
   endtask

   task automatic drain_all();
      req_bus.valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      drain_all();
      test_random(1700);
      drain_all();
      quiet = 1'b1;
      test_random(300);
      drain_all();
      repeat (vcc_tb_types::LATENCY + 10) @(posedge clock);
      $display("Sent %0d capsule pairs, checked %0d results, %0d of them collisions.",
               sent, got, hits);
      if (!failed && expected_q.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
